>>> rtl/assert_macros.svh
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define BLE_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// condition must never be seen at a clock edge outside reset
`define BLE_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define BLE_ASSERT(name, clk, rst_n, prop)
`define BLE_ASSERT_NEVER(name, clk, rst_n, cond)

`endif

`endif

>>> rtl/ble_pkg.sv
// types and codes for the bounded list engine
`default_nettype none

package ble_pkg;

  typedef enum logic [2:0] {
    REQ_PUSH_BACK  = 3'd0,
    REQ_PUSH_FRONT = 3'd1,
    REQ_DELETE     = 3'd2,
    REQ_CLEAR      = 3'd3,
    REQ_REVERSE    = 3'd4,
    REQ_PRINT      = 3'd5
  } req_type_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_EMPTY     = 2'd2,
    STS_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_SHIFT,
    ST_PRINT
  } state_e;

  // which logical position the memory read targets, relative to the walk index
  typedef enum logic [1:0] {
    RD_IDX,
    RD_IDX1,
    RD_IDX2
  } rd_sel_e;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] item_value;
    logic [1:0]         status;
    logic               last;
  } rsp_t;

  typedef struct packed {
    logic    load;
    logic    push_back;
    logic    push_front;
    logic    clear;
    logic    reverse;
    logic    rd;
    rd_sel_e rd_sel;
    logic    wr_shift;
    logic    idx_inc;
    logic    dec_count;
    logic    emit;
    logic    emit_item;
    status_e emit_status;
    logic    emit_last;
  } cmd_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic       empty;
    logic       full;
    logic       match;
    logic       idx_last;
    logic       idx_next_last;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/bounded_list_engine.sv
// top level of the bounded list engine: ordered list of up to DEPTH signed words
//
//   channel   ports                         transfer
//   request   start_i, busy_o, req_i        start_i high while busy_o low
//   result    rsp_valid_o, rsp_o            rsp_valid_o high for one cycle
//
// push, clear and reverse pass through the decode state; the result
// appears as busy goes low.
// print streams one result per cycle, one memory read per entry through the
// single read port.
// delete scans then moves later entries down one per cycle, through the
// single read port and single write port.
// reset empties the list at once; the entry memory is never cleared.
// results cannot be stalled; a new request may start while the previous
// result is still on the result ports.
//
// the list lives in a circular buffer with a head pointer and a direction
// bit, so push front and reverse are pointer updates and never move data
`default_nettype none

module bounded_list_engine
  import ble_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int ELEM_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  req_t req_i,
  output logic rsp_valid_o,
  output rsp_t rsp_o
);

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: decodes the latched request and steps the list walk
  ble_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  // storage, pointers, compare and the registered result
  ble_datapath #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

endmodule

`default_nettype wire

>>> rtl/ble_ctrl.sv
// control state machine of the bounded list engine
`default_nettype none
`include "assert_macros.svh"

module ble_ctrl
  import ble_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d            = state_q;
    cmd_o              = '0;
    cmd_o.rd_sel       = RD_IDX;
    cmd_o.emit_status  = STS_OK;
    busy_o             = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d = ST_IDLE;
        unique case (sts_i.req_type)
          REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
            cmd_o.emit      = 1'b1;
            cmd_o.emit_last = 1'b1;
            if (sts_i.full) begin
              cmd_o.emit_status = STS_FULL;
            end else if (sts_i.req_type == REQ_PUSH_BACK) begin
              cmd_o.push_back = 1'b1;
            end else begin
              cmd_o.push_front = 1'b1;
            end
          end
          REQ_DELETE: begin
            if (sts_i.empty) begin
              cmd_o.emit        = 1'b1;
              cmd_o.emit_last   = 1'b1;
              cmd_o.emit_status = STS_NOT_FOUND;
            end else begin
              cmd_o.rd = 1'b1;
              state_d  = ST_SCAN;
            end
          end
          REQ_CLEAR: begin
            cmd_o.clear     = 1'b1;
            cmd_o.emit      = 1'b1;
            cmd_o.emit_last = 1'b1;
          end
          REQ_REVERSE: begin
            cmd_o.emit      = 1'b1;
            cmd_o.emit_last = 1'b1;
            if (sts_i.empty) begin
              cmd_o.emit_status = STS_EMPTY;
            end else begin
              cmd_o.reverse = 1'b1;
            end
          end
          REQ_PRINT: begin
            if (sts_i.empty) begin
              cmd_o.emit        = 1'b1;
              cmd_o.emit_last   = 1'b1;
              cmd_o.emit_status = STS_EMPTY;
            end else begin
              cmd_o.rd = 1'b1;
              state_d  = ST_PRINT;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      ST_SCAN: begin
        // read data holds the entry at the walk index
        if (sts_i.match && sts_i.idx_last) begin
          cmd_o.dec_count = 1'b1;
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = 1'b1;
          state_d         = ST_IDLE;
        end else if (sts_i.match) begin
          cmd_o.rd     = 1'b1;
          cmd_o.rd_sel = RD_IDX1;
          state_d      = ST_SHIFT;
        end else if (sts_i.idx_last) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_last   = 1'b1;
          cmd_o.emit_status = STS_NOT_FOUND;
          state_d           = ST_IDLE;
        end else begin
          cmd_o.rd      = 1'b1;
          cmd_o.rd_sel  = RD_IDX1;
          cmd_o.idx_inc = 1'b1;
        end
      end
      ST_SHIFT: begin
        // read data holds the entry after the walk index: move it down one
        cmd_o.wr_shift = 1'b1;
        cmd_o.idx_inc  = 1'b1;
        if (sts_i.idx_next_last) begin
          cmd_o.dec_count = 1'b1;
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = 1'b1;
          state_d         = ST_IDLE;
        end else begin
          cmd_o.rd     = 1'b1;
          cmd_o.rd_sel = RD_IDX2;
        end
      end
      ST_PRINT: begin
        cmd_o.emit      = 1'b1;
        cmd_o.emit_item = 1'b1;
        cmd_o.emit_last = sts_i.idx_last;
        if (sts_i.idx_last) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.rd      = 1'b1;
          cmd_o.rd_sel  = RD_IDX1;
          cmd_o.idx_inc = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  `BLE_ASSERT_NEVER(a_idle_no_emit, clk_i, rst_ni, (state_q == ST_IDLE) && cmd_o.emit)
  `BLE_ASSERT(a_last_ends_req, clk_i, rst_ni, (cmd_o.emit && cmd_o.emit_last) |=> (state_q == ST_IDLE))
  `BLE_ASSERT_NEVER(a_idle_no_write, clk_i, rst_ni, (state_q == ST_IDLE) && (cmd_o.push_back || cmd_o.push_front || cmd_o.wr_shift))

endmodule

`default_nettype wire

>>> rtl/ble_datapath.sv
// list storage, pointers and result register of the bounded list engine
`default_nettype none
`include "assert_macros.svh"

module ble_datapath
  import ble_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int ELEM_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t req_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output logic rsp_valid_o,
  output rsp_t rsp_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 2;

  // circular storage: logical position i sits at base +/- i depending on direction
  logic [ELEM_WIDTH-1:0] mem_q [DEPTH];

  logic [AW-1:0]         base_q, base_d;
  logic                  rev_q, rev_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic [2:0]            req_type_q;
  logic [ELEM_WIDTH-1:0] val_q;
  logic [ELEM_WIDTH-1:0] rd_data_q;
  logic                  rsp_valid_q;
  rsp_t                  rsp_q, rsp_d;

  logic signed [63:0]         val_ext;
  logic signed [ELEM_WIDTH-1:0] rd_s;
  logic signed [63:0]         rd_ext;
  logic [CW:0]                idx_p1, idx_p2;
  logic [AW-1:0]              rd_addr;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [ELEM_WIDTH-1:0]      wr_data;
  logic [AW-1:0]              pre_addr;

  function automatic logic [AW-1:0] phys(logic [AW-1:0] b, logic [CW:0] off, logic down);
    logic [SW-1:0] s;
    if (down) begin
      s = SW'(b) + SW'(DEPTH) - SW'(off);
    end else begin
      s = SW'(b) + SW'(off);
    end
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign val_ext = $signed(req_i.value);
  assign rd_s    = rd_data_q;
  assign rd_ext  = rd_s;

  assign idx_p1 = {1'b0, idx_q} + (CW + 1)'(1);
  assign idx_p2 = {1'b0, idx_q} + (CW + 1)'(2);

  // slot just ahead of the first entry
  assign pre_addr = phys(base_q, (CW + 1)'(1), ~rev_q);

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_IDX:  rd_addr = phys(base_q, {1'b0, idx_q}, rev_q);
      RD_IDX1: rd_addr = phys(base_q, idx_p1, rev_q);
      RD_IDX2: rd_addr = phys(base_q, idx_p2, rev_q);
      default: rd_addr = phys(base_q, {1'b0, idx_q}, rev_q);
    endcase
  end

  // write sources are exclusive; most cycles none of them is active
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = phys(base_q, {1'b0, idx_q}, rev_q);
    wr_data = rd_data_q;
    if (cmd_i.push_back) begin
      wr_en   = 1'b1;
      wr_addr = phys(base_q, {1'b0, count_q}, rev_q);
      wr_data = val_q;
    end else if (cmd_i.push_front) begin
      wr_en   = 1'b1;
      wr_addr = pre_addr;
      wr_data = val_q;
    end else if (cmd_i.wr_shift) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd) begin
      rd_data_q <= mem_q[rd_addr];
    end
    if (cmd_i.load) begin
      req_type_q <= req_i.req_type;
      val_q      <= val_ext[ELEM_WIDTH-1:0];
    end
    rsp_q <= rsp_d;
  end

  always_comb begin
    base_d  = base_q;
    rev_d   = rev_q;
    count_d = count_q;
    idx_d   = idx_q;
    if (cmd_i.load) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_p1[CW-1:0];
    end
    if (cmd_i.push_back) begin
      count_d = count_q + CW'(1);
    end
    if (cmd_i.push_front) begin
      base_d  = pre_addr;
      count_d = count_q + CW'(1);
    end
    if (cmd_i.dec_count) begin
      count_d = count_q - CW'(1);
    end
    if (cmd_i.clear) begin
      count_d = '0;
    end
    if (cmd_i.reverse) begin
      base_d = phys(base_q, {1'b0, count_q} - (CW + 1)'(1), rev_q);
      rev_d  = ~rev_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      rev_q       <= 1'b0;
      count_q     <= '0;
      idx_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      base_q      <= base_d;
      rev_q       <= rev_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      rsp_valid_q <= cmd_i.emit;
    end
  end

  always_comb begin
    rsp_d.item_value = cmd_i.emit_item ? rd_ext[31:0] : '0;
    rsp_d.status     = cmd_i.emit_status;
    rsp_d.last       = cmd_i.emit_last;
  end

  always_comb begin
    sts_o.req_type      = req_type_q;
    sts_o.empty         = (count_q == '0);
    sts_o.full          = (count_q >= CW'(DEPTH));
    sts_o.match         = (rd_data_q == val_q);
    sts_o.idx_last      = (idx_p1 == {1'b0, count_q});
    sts_o.idx_next_last = (idx_p2 == {1'b0, count_q});
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  `BLE_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CW'(DEPTH))
  `BLE_ASSERT_NEVER(a_push_when_full, clk_i, rst_ni, (cmd_i.push_back || cmd_i.push_front) && (count_q >= CW'(DEPTH)))
  `BLE_ASSERT(a_error_is_last, clk_i, rst_ni, (rsp_valid_q && (rsp_q.status != STS_OK)) |-> rsp_q.last)

endmodule

`default_nettype wire

>>> sim/tb_bounded_list_engine.sv
// testbench for the bounded list engine: directed corner cases, then randomized requests
`timescale 1ns / 100ps
`default_nettype none

module tb_bounded_list_engine;
  import ble_pkg::*;

  localparam int LIST_DEPTH = 16;
  localparam int ELEM_BITS  = 32;

  // request codes the block leaves undecoded; they must produce no result
  localparam logic [2:0] REQ_SPARE_A = 3'd6;
  localparam logic [2:0] REQ_SPARE_B = 3'd7;

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  // settle time after the last result: a print walks the whole list
  localparam int TAIL_CYCLES = 2 * LIST_DEPTH + 8;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  req_t req_i;
  logic rsp_valid_o;
  rsp_t rsp_o;

  // shadow copy of the list contents, position 0 first
  logic signed [31:0] list_shadow[$];
  // results the block still owes, oldest first
  rsp_t               pending_rsp[$];

  int fail_count;
  bit gaps_enabled;

  bounded_list_engine #(
    .DEPTH      (LIST_DEPTH),
    .ELEM_WIDTH (ELEM_BITS)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // list behavior: apply one accepted request to the shadow list and
  // queue every result it owes
  // ---------------------------------------------------------------------
  function automatic rsp_t make_rsp(input logic signed [31:0] item, input status_e sts,
                                    input logic fin);
    rsp_t r;
    r.item_value = item;
    r.status     = sts;
    r.last       = fin;
    return r;
  endfunction

  task automatic apply_list_request(input logic [2:0] code, input logic signed [31:0] val);
    int pos;
    int lo;
    int hi;
    logic signed [31:0] tmp;
    case (code)
      REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
        if (list_shadow.size() >= LIST_DEPTH) begin
          // full list drops the value
          pending_rsp.push_back(make_rsp('0, STS_FULL, 1'b1));
        end else begin
          if (code == REQ_PUSH_BACK) list_shadow.push_back(val);
          else list_shadow.push_front(val);
          pending_rsp.push_back(make_rsp('0, STS_OK, 1'b1));
        end
      end
      REQ_DELETE: begin
        pos = -1;
        for (int i = 0; i < list_shadow.size(); i++) begin
          if (pos < 0 && list_shadow[i] == val) pos = i;
        end
        if (pos < 0) begin
          pending_rsp.push_back(make_rsp('0, STS_NOT_FOUND, 1'b1));
        end else begin
          list_shadow.delete(pos);
          pending_rsp.push_back(make_rsp('0, STS_OK, 1'b1));
        end
      end
      REQ_CLEAR: begin
        list_shadow.delete();
        pending_rsp.push_back(make_rsp('0, STS_OK, 1'b1));
      end
      REQ_REVERSE: begin
        if (list_shadow.size() == 0) begin
          pending_rsp.push_back(make_rsp('0, STS_EMPTY, 1'b1));
        end else begin
          lo = 0;
          hi = list_shadow.size() - 1;
          while (lo < hi) begin
            tmp             = list_shadow[lo];
            list_shadow[lo] = list_shadow[hi];
            list_shadow[hi] = tmp;
            lo++;
            hi--;
          end
          pending_rsp.push_back(make_rsp('0, STS_OK, 1'b1));
        end
      end
      REQ_PRINT: begin
        if (list_shadow.size() == 0) begin
          pending_rsp.push_back(make_rsp('0, STS_EMPTY, 1'b1));
        end else begin
          for (int i = 0; i < list_shadow.size(); i++) begin
            pending_rsp.push_back(make_rsp(list_shadow[i], STS_OK,
                                           (i == list_shadow.size() - 1)));
          end
        end
      end
      default: ; // spare codes: ignored
    endcase
  endtask

  // ---------------------------------------------------------------------
  // request side: idle for a random gap, raise start and hold the request
  // until a transfer; start stays high after the transfer so back-to-back
  // requests never lower and raise it in the same step
  // ---------------------------------------------------------------------
  task automatic send_request(input logic [2:0] code, input logic signed [31:0] val);
    int gap;
    gap = gaps_enabled ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i        <= 1'b1;
    req_i.req_type <= code;
    req_i.value    <= val;
    do @(posedge clk_i); while (busy_o);
    // transfer happened at this edge
    apply_list_request(code, val);
  endtask

  // ---------------------------------------------------------------------
  // result side: every strobe is matched against the oldest expectation
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : rsp_check
    rsp_t want;
    if (rst_ni && rsp_valid_o) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected result: item_value %0d status %0d last %0b",
               rsp_o.item_value, rsp_o.status, rsp_o.last);
        fail_count++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_o.item_value !== want.item_value) begin
          $error("item_value: expected %0d, got %0d", want.item_value, rsp_o.item_value);
          fail_count++;
        end
        if (rsp_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_o.status);
          fail_count++;
        end
        if (rsp_o.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, rsp_o.last);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // value sources
  // ---------------------------------------------------------------------
  // small values give duplicates, so delete meets repeated entries
  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       v = VAL_MIN;
          1:       v = VAL_MAX;
          2:       v = '0;
          default: v = -32'sd1;
        endcase
      end
      1, 2, 3, 4: v = $signed($urandom_range(0, 15)) - 32'sd8;
      default:    v = $urandom;
    endcase
    return v;
  endfunction

  // mostly a value that is stored, so deletes hit as well as miss
  function automatic logic signed [31:0] pick_delete_value();
    if (list_shadow.size() > 0 && $urandom_range(0, 3) != 0)
      return list_shadow[$urandom_range(0, list_shadow.size() - 1)];
    return pick_value();
  endfunction

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------
  task automatic test_directed_corners();
    // requests on an empty list
    send_request(REQ_PRINT, '0);
    send_request(REQ_REVERSE, '0);
    send_request(REQ_DELETE, '0);
    send_request(REQ_CLEAR, '0);
    // single entry reverse leaves it in place
    send_request(REQ_PUSH_BACK, VAL_MAX);
    send_request(REQ_REVERSE, '0);
    send_request(REQ_PUSH_FRONT, VAL_MIN);
    send_request(REQ_PUSH_BACK, '0);
    send_request(REQ_PUSH_FRONT, -32'sd1);
    send_request(REQ_PRINT, '0);
    send_request(REQ_REVERSE, '0);
    send_request(REQ_PRINT, '0);
    // middle hit, miss, tail hit
    send_request(REQ_DELETE, VAL_MIN);
    send_request(REQ_DELETE, 32'sd5);
    send_request(REQ_DELETE, -32'sd1);
    send_request(REQ_SPARE_A, 32'sh5555_aaaa);
    send_request(REQ_SPARE_B, 32'shaaaa_5555);
    send_request(REQ_CLEAR, '0);
    send_request(REQ_PRINT, '0);
  endtask

  // fill to capacity, push past it, then walk and shrink the full list
  task automatic test_full_list();
    repeat (3) begin
      send_request(REQ_CLEAR, '0);
      while (list_shadow.size() < LIST_DEPTH) begin
        send_request($urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK, pick_value());
      end
      repeat ($urandom_range(1, 3)) begin
        send_request($urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK, pick_value());
      end
      send_request(REQ_PRINT, '0);
      send_request(REQ_REVERSE, '0);
      send_request(REQ_PRINT, '0);
      repeat (4) send_request(REQ_DELETE, pick_delete_value());
    end
  endtask

  // weighted mix; pushes outweigh deletes so the list keeps reaching full
  task automatic test_random_mix();
    int pick;
    for (int n = 0; n < 270; n++) begin
      // stretches with no idle cycles and stretches with random gaps are picked at random
      if (n % 30 == 0) gaps_enabled = ($urandom_range(0, 2) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 24)      send_request(REQ_PUSH_BACK, pick_value());
      else if (pick < 44) send_request(REQ_PUSH_FRONT, pick_value());
      else if (pick < 63) send_request(REQ_DELETE, pick_delete_value());
      else if (pick < 77) send_request(REQ_PRINT, $urandom);
      else if (pick < 89) send_request(REQ_REVERSE, $urandom);
      else if (pick < 93) send_request(REQ_CLEAR, $urandom);
      else if (pick < 96) send_request(REQ_SPARE_A, $urandom);
      else if (pick < 98) send_request(REQ_SPARE_B, $urandom);
      else                send_request(REQ_PUSH_BACK, pick_value());
    end
    gaps_enabled = 1'b1;
  endtask

  // ---------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    req_i        = '0;
    fail_count   = 0;
    gaps_enabled = 1'b1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_corners();
    test_full_list();
    test_random_mix();

    start_i <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    // anything arriving now is an extra result
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog: far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire

>>> bounded_list_engine.f
+incdir+rtl
rtl/ble_pkg.sv
rtl/ble_ctrl.sv
rtl/ble_datapath.sv
rtl/bounded_list_engine.sv
sim/tb_bounded_list_engine.sv
